// ===== sv/bmpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the 24-bit BMP stream decoder.
// ----------------------------------------------------------------------------
package bmpd_pkg;

    localparam int unsigned MAX_DIM      = 4096;
    localparam int unsigned COORD_W      = 12;
    localparam int unsigned HEADER_BYTES = 54;
    localparam int unsigned POS_W        = 6;
    localparam int unsigned DEPTH_W      = 16;
    localparam int unsigned DIM_FIELD_W  = 32;

    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_BAD_DEPTH = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;

    typedef struct packed {
        logic [7:0] data;
        logic       sof;
    } beat_t;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row_index;
        logic [1:0]         status;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

// ===== sv/bmpd_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_in_stage
// Input register: holds one byte beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module bmpd_in_stage
    import bmpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  byte_valid,
    output logic       byte_stall,
    input  wire beat_t beat_in,
    input  wire logic  advance,
    output logic       buf_valid,
    output beat_t      buf_beat
);

    logic  valid_reg;
    beat_t beat_reg;

    assign byte_stall = valid_reg && !advance;
    assign buf_valid  = valid_reg;
    assign buf_beat   = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            beat_reg <= beat_in;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bmpd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_decode
// Header parser and pixel assembler: one byte per fire, at most one result.
// ----------------------------------------------------------------------------
module bmpd_decode
    import bmpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire beat_t beat,
    output logic       res_valid,
    output result_t    res
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXEL,
        PH_PAD,
        PH_IDLE
    } phase_t;

    localparam logic [POS_W-1:0] POS_W0   = POS_W'(18);
    localparam logic [POS_W-1:0] POS_W3   = POS_W'(21);
    localparam logic [POS_W-1:0] POS_H0   = POS_W'(22);
    localparam logic [POS_W-1:0] POS_H3   = POS_W'(25);
    localparam logic [POS_W-1:0] POS_D0   = POS_W'(28);
    localparam logic [POS_W-1:0] POS_D1   = POS_W'(29);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HEADER_BYTES - 1);

    phase_t                   phase_reg,  phase_next,  phase_cur;
    logic [POS_W-1:0]         pos_reg,    pos_next,    pos_cur;
    logic [DIM_FIELD_W-1:0]   width_reg,  width_next,  width_cur;
    logic [DIM_FIELD_W-1:0]   height_reg, height_next, height_cur;
    logic [DEPTH_W-1:0]       depth_reg,  depth_next,  depth_cur;
    logic [1:0]               comp_reg,   comp_next,   comp_cur;
    logic [7:0]               blue_reg,   blue_next,   blue_cur;
    logic [7:0]               green_reg,  green_next,  green_cur;
    logic [COORD_W-1:0]       col_reg,    col_next,    col_cur;
    logic [COORD_W-1:0]       row_reg,    row_next,    row_cur;
    logic [1:0]               pad_reg,    pad_next,    pad_cur;
    logic                     col_end;
    logic                     row_end;
    logic [1:0]               pad_dec;
    logic [1:0]               w_sel;
    logic [1:0]               h_sel;

    always_comb
    begin
        if (beat.sof)
        begin
            phase_cur  = PH_HEADER;
            pos_cur    = '0;
            width_cur  = '0;
            height_cur = '0;
            depth_cur  = '0;
            comp_cur   = '0;
            blue_cur   = '0;
            green_cur  = '0;
            col_cur    = '0;
            row_cur    = '0;
            pad_cur    = '0;
        end
        else
        begin
            phase_cur  = phase_reg;
            pos_cur    = pos_reg;
            width_cur  = width_reg;
            height_cur = height_reg;
            depth_cur  = depth_reg;
            comp_cur   = comp_reg;
            blue_cur   = blue_reg;
            green_cur  = green_reg;
            col_cur    = col_reg;
            row_cur    = row_reg;
            pad_cur    = pad_reg;
        end
    end

    assign col_end = (DIM_FIELD_W'(col_cur) + DIM_FIELD_W'(1)) >= width_cur;
    assign row_end = (DIM_FIELD_W'(row_cur) + DIM_FIELD_W'(1)) >= height_cur;
    assign pad_dec = pad_cur - 2'd1;
    assign w_sel   = pos_cur[1:0] - POS_W0[1:0];
    assign h_sel   = pos_cur[1:0] - POS_H0[1:0];

    always_comb
    begin
        phase_next  = phase_cur;
        pos_next    = pos_cur;
        width_next  = width_cur;
        height_next = height_cur;
        depth_next  = depth_cur;
        comp_next   = comp_cur;
        blue_next   = blue_cur;
        green_next  = green_cur;
        col_next    = col_cur;
        row_next    = row_cur;
        pad_next    = pad_cur;
        res_valid   = 1'b0;
        res         = '0;

        unique case (phase_cur)
            PH_HEADER:
            begin
                if (pos_cur >= POS_W0 && pos_cur <= POS_W3)
                begin
                    width_next[{w_sel, 3'b000} +: 8] = beat.data;
                end
                else if (pos_cur >= POS_H0 && pos_cur <= POS_H3)
                begin
                    height_next[{h_sel, 3'b000} +: 8] = beat.data;
                end
                else if (pos_cur == POS_D0)
                begin
                    depth_next[7:0] = beat.data;
                end
                else if (pos_cur == POS_D1)
                begin
                    depth_next[15:8] = beat.data;
                end

                if (pos_cur != POS_LAST)
                begin
                    pos_next = pos_cur + POS_W'(1);
                end
                else
                begin
                    pos_next = '0;
                    priority if (depth_cur != DEPTH_W'(24))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_DEPTH;
                    end
                    else if (width_cur > DIM_FIELD_W'(MAX_DIM)
                             || height_cur > DIM_FIELD_W'(MAX_DIM))
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_SIZE;
                    end
                    else if (width_cur == '0 || height_cur == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_PIXEL;
                        comp_next  = '0;
                        col_next   = '0;
                        row_next   = '0;
                    end
                end
            end
            PH_PIXEL:
            begin
                unique case (comp_cur)
                    2'd0:
                    begin
                        blue_next = beat.data;
                        comp_next = 2'd1;
                    end
                    2'd1:
                    begin
                        green_next = beat.data;
                        comp_next  = 2'd2;
                    end
                    default:
                    begin
                        comp_next     = '0;
                        res_valid     = 1'b1;
                        res.red       = beat.data;
                        res.green     = green_cur;
                        res.blue      = blue_cur;
                        res.column    = col_cur;
                        res.row_index = row_cur;
                        res.status    = ST_PIXEL;
                        res.last      = col_end && row_end;
                        if (col_end)
                        begin
                            pad_next = width_cur[1:0];
                            if (width_cur[1:0] != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                            else
                            begin
                                col_next = '0;
                                if (row_end)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    row_next   = row_cur + COORD_W'(1);
                                    phase_next = PH_PIXEL;
                                end
                            end
                        end
                        else
                        begin
                            col_next = col_cur + COORD_W'(1);
                        end
                    end
                endcase
            end
            PH_PAD:
            begin
                pad_next = pad_dec;
                if (pad_dec == 2'd0)
                begin
                    col_next = '0;
                    if (row_end)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        row_next   = row_cur + COORD_W'(1);
                        phase_next = PH_PIXEL;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            depth_reg  <= '0;
            comp_reg   <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            pad_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            comp_reg   <= comp_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            pad_reg    <= pad_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bmpd_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmpd_out_stage
// Result register: holds one pixel or error beat until the receiver takes it.
// ----------------------------------------------------------------------------
module bmpd_out_stage
    import bmpd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load_valid,
    input  wire result_t load_res,
    output logic         can_load,
    output logic         pixel_valid,
    input  wire logic    pixel_stall,
    output result_t      held
);

    logic    valid_reg;
    result_t res_reg;

    assign can_load    = !valid_reg || !pixel_stall;
    assign pixel_valid = valid_reg;
    assign held        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

endmodule
`default_nettype wire

// ===== sv/bmp24_stream_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_decoder_unit
// Byte-serial decoder for uncompressed 24-bit BMP files.
//
// Byte channel: data_byte with start_of_file, qualified by byte_valid and
// held off by byte_stall. start_of_file restarts the decoder on that byte.
// Pixel channel: red, green, blue, column, row_index, status, last_pixel,
// qualified by pixel_valid and held off by pixel_stall. status flags a bad
// bit depth or an oversized image once per file, with zero pixel fields.
// Throughput: one byte per cycle while pixel_stall holds nothing back; every
// third pixel byte yields a beat. An accepted byte reaches the pixel side
// as a beat by way of the input register, then the result register.
// While the receiver stalls, the result register holds its beat, the
// input register holds one more byte, and only then is byte_stall raised.
// Reset empties both registers and returns the parser to header byte 0.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder_unit
    import bmpd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               byte_valid,
    output logic                    byte_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               start_of_file,
    output logic                    pixel_valid,
    input  wire logic               pixel_stall,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic [COORD_W-1:0]      column,
    output logic [COORD_W-1:0]      row_index,
    output logic [1:0]              status,
    output logic                    last_pixel
);

    beat_t   beat_in;
    beat_t   buf_beat;
    logic    buf_valid;
    logic    can_load;
    logic    fire;
    logic    res_valid;
    result_t res;
    result_t held;

    assign beat_in.data = data_byte;
    assign beat_in.sof  = start_of_file;
    assign fire         = buf_valid && can_load;

    bmpd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .beat_in    (beat_in),
        .advance    (can_load),
        .buf_valid  (buf_valid),
        .buf_beat   (buf_beat)
    );

    bmpd_decode u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .beat      (buf_beat),
        .res_valid (res_valid),
        .res       (res)
    );

    bmpd_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (fire && res_valid),
        .load_res    (res),
        .can_load    (can_load),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .held        (held)
    );

    assign red        = held.red;
    assign green      = held.green;
    assign blue       = held.blue;
    assign column     = held.column;
    assign row_index  = held.row_index;
    assign status     = held.status;
    assign last_pixel = held.last;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && status != ST_PIXEL |->
            red == 8'd0 && green == 8'd0 && blue == 8'd0
            && column == '0 && row_index == '0 && !last_pixel)
        else $error("error beat carries nonzero pixel fields");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && last_pixel |-> status == ST_PIXEL)
        else $error("last_pixel set on an error beat");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> buf_valid && pixel_valid && pixel_stall)
        else $error("byte_stall raised without a full pipeline");

endmodule
`default_nettype wire
